// ===== sv/utf8v_pkg.sv =====
`default_nettype none
package utf8v_pkg;

    localparam int unsigned CpWidth = 21;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // length classes
    localparam logic [1:0] LC_TWO   = 2'd1;
    localparam logic [1:0] LC_THREE = 2'd2;
    localparam logic [1:0] LC_FOUR  = 2'd3;

    localparam logic [CpWidth-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CpWidth-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CpWidth-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CpWidth-1:0] CP_BMP_MAX   = 21'h00FFFF;
    localparam logic [CpWidth-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CpWidth-1:0] CP_LOW_SURR  = 21'h00DC00;
    localparam logic [CpWidth-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CpWidth-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CpWidth-1:0] MIN_FOUR     = 21'h010000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_unit;
        logic [1:0]         status;
        logic               run_last;
        logic               text_done;
    } result_t;

    // results of one byte: count 0..2, first in res0
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

endpackage
`default_nettype wire

// ===== sv/utf8v_in_stage.sv =====
`default_nettype none
module utf8v_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire utf8v_pkg::in_item_t s_item,
    output logic                    item_valid,
    output utf8v_pkg::in_item_t     item,
    input  wire logic               item_take
);

    logic                valid_reg;
    logic                valid_next;
    utf8v_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/utf8v_decode.sv =====
`default_nettype none
module utf8v_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_wide,
    input  wire logic                item_valid,
    input  wire utf8v_pkg::in_item_t item,
    output logic                     item_take,
    input  wire logic                out_space,
    output utf8v_pkg::dec_out_t      dec
);

    logic                             wide_reg;
    logic [1:0]                       bytes_pending_reg, bytes_pending_next;
    logic [utf8v_pkg::CpWidth-1:0]    partial_point_reg, partial_point_next;
    logic [1:0]                       length_class_reg, length_class_next;
    logic                             discarding_reg, discarding_next;

    logic [7:0]                       b;
    logic                             eot;
    logic [utf8v_pkg::CpWidth-1:0]    cp;
    logic [utf8v_pkg::CpWidth-1:0]    minimum;
    logic [utf8v_pkg::CpWidth-1:0]    supp;
    logic [1:0]                       pend_dec;
    logic                             do_emit;
    logic                             do_fail;
    logic [1:0]                       fail_status;

    always_comb
    begin
        b   = item.data_byte;
        eot = item.end_of_text;

        bytes_pending_next = bytes_pending_reg;
        partial_point_next = partial_point_reg;
        length_class_next  = length_class_reg;
        discarding_next    = discarding_reg;
        do_emit            = 1'b0;
        do_fail            = 1'b0;
        fail_status        = utf8v_pkg::ST_INVALID;
        cp                 = {{(utf8v_pkg::CpWidth-8){1'b0}}, b};
        pend_dec           = bytes_pending_reg - 2'd1;

        case (length_class_reg)
            utf8v_pkg::LC_TWO:   minimum = utf8v_pkg::MIN_TWO;
            utf8v_pkg::LC_THREE: minimum = utf8v_pkg::MIN_THREE;
            default:             minimum = utf8v_pkg::MIN_FOUR;
        endcase

        if (discarding_reg)
        begin
            if (eot)
            begin
                discarding_next = 1'b0;
            end
        end
        else if (bytes_pending_reg == 2'd0)
        begin
            if (!b[7])
            begin
                do_emit = 1'b1;
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    partial_point_next = {{(utf8v_pkg::CpWidth-5){1'b0}}, b[4:0]};
                    bytes_pending_next = 2'd1;
                    length_class_next  = utf8v_pkg::LC_TWO;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_point_next = {{(utf8v_pkg::CpWidth-4){1'b0}}, b[3:0]};
                    bytes_pending_next = 2'd2;
                    length_class_next  = utf8v_pkg::LC_THREE;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_point_next = {{(utf8v_pkg::CpWidth-3){1'b0}}, b[2:0]};
                    bytes_pending_next = 2'd3;
                    length_class_next  = utf8v_pkg::LC_FOUR;
                end
                else
                begin
                    do_fail = 1'b1;
                end
                if (!do_fail && eot)
                begin
                    do_fail     = 1'b1;
                    fail_status = utf8v_pkg::ST_TRUNC;
                end
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            do_fail = 1'b1;
        end
        else
        begin
            cp = {partial_point_reg[utf8v_pkg::CpWidth-7:0], b[5:0]};
            partial_point_next = cp;
            bytes_pending_next = pend_dec;
            if (pend_dec != 2'd0)
            begin
                if (eot)
                begin
                    do_fail     = 1'b1;
                    fail_status = utf8v_pkg::ST_TRUNC;
                end
            end
            else if (cp < minimum || cp > utf8v_pkg::CP_MAX ||
                     (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI))
            begin
                do_fail = 1'b1;
            end
            else
            begin
                do_emit = 1'b1;
            end
        end

        // completion or error drops the partial character
        if (do_emit || do_fail)
        begin
            bytes_pending_next = 2'd0;
            partial_point_next = '0;
            length_class_next  = 2'd0;
        end
        if (do_fail)
        begin
            discarding_next = !eot;
        end

        supp = cp - utf8v_pkg::CP_SUPP_BASE;

        dec.count          = 2'd0;
        dec.res0.code_unit = cp;
        dec.res0.status    = utf8v_pkg::ST_OK;
        dec.res0.run_last  = 1'b1;
        dec.res0.text_done = eot;
        dec.res1.code_unit = utf8v_pkg::CP_LOW_SURR | {11'd0, supp[9:0]};
        dec.res1.status    = utf8v_pkg::ST_OK;
        dec.res1.run_last  = 1'b1;
        dec.res1.text_done = eot;

        if (do_fail)
        begin
            dec.count          = 2'd1;
            dec.res0.code_unit = '0;
            dec.res0.status    = fail_status;
            dec.res0.text_done = 1'b1;
        end
        else if (do_emit)
        begin
            if (wide_reg || cp <= utf8v_pkg::CP_BMP_MAX)
            begin
                dec.count = 2'd1;
            end
            else
            begin
                dec.count          = 2'd2;
                dec.res0.code_unit = utf8v_pkg::CP_SURR_LO | {11'd0, supp[19:10]};
                dec.res0.run_last  = 1'b0;
                dec.res0.text_done = 1'b0;
            end
        end
    end

    assign item_take = item_valid && (dec.count == 2'd0 || out_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg          <= 1'b0;
            bytes_pending_reg <= 2'd0;
            partial_point_reg <= '0;
            length_class_reg  <= 2'd0;
            discarding_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                wide_reg <= cfg_wide;
            end
            if (item_take)
            begin
                bytes_pending_reg <= bytes_pending_next;
                partial_point_reg <= partial_point_next;
                length_class_reg  <= length_class_next;
                discarding_reg    <= discarding_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/utf8v_out_stage.sv =====
`default_nettype none
module utf8v_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire utf8v_pkg::dec_out_t dec,
    output logic                     space,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output utf8v_pkg::result_t       m_result
);

    logic [1:0]         cnt_reg, cnt_next;
    utf8v_pkg::result_t slot0_reg;
    utf8v_pkg::result_t slot1_reg;
    logic               take;

    assign m_valid  = cnt_reg != 2'd0;
    assign m_result = slot0_reg;
    assign take     = m_valid && m_ready;
    assign space    = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && take);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load && dec.count != 2'd0)
        begin
            cnt_next = dec.count;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && dec.count != 2'd0)
        begin
            slot0_reg <= dec.res0;
            slot1_reg <= dec.res1;
        end
        else if (take)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/utf8_validating_decoder_top.sv =====
`default_nettype none
// UTF-8 validating decoder.
// Slave stream: one beat per byte, tdata = data_byte, tlast flags the final byte
// of the string. Master stream: one beat per result; tdata carries the UTF-16
// unit (or whole code point in wide mode) and run_last, tuser the status
// (ok, invalid, truncated), tlast the final result of the string.
// A character beyond the BMP gives two beats (high then low surrogate) unless
// wide mode is set. An error gives a single zero beat with tlast high, then
// bytes are dropped up to and including the next tlast byte.
// cfg channel: cfg_data bit 0 = wide mode; always ready, write only while idle.
// Path: a byte is registered at the input stage, decoded combinationally into
// the result register, and shown straight from that register.
// Throughput: one byte per cycle while the receiver is ready; a surrogate pair
// holds the input until the two-slot result register, draining one beat per cycle, frees a slot.
// Reset clears the decode state, wide mode and both stages; no beats pending.
// When the receiver stalls, the result register fills and the input stage
// holds its byte; s_axis_tready drops once both are occupied.
module utf8_validating_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_text
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_unit, [21] run_last, zero above
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast,   // text_done
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data        // wide_output
);

    utf8v_pkg::in_item_t s_item;
    utf8v_pkg::in_item_t item;
    logic                item_valid;
    logic                item_take;
    logic                out_space;
    utf8v_pkg::dec_out_t dec;
    utf8v_pkg::result_t  m_result;

    assign cfg_ready          = 1'b1;
    assign s_item.data_byte   = s_axis_tdata;
    assign s_item.end_of_text = s_axis_tlast;

    utf8v_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    utf8v_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_wide   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_space  (out_space),
        .dec        (dec)
    );

    utf8v_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_take),
        .dec      (dec),
        .space    (out_space),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {2'b00, m_result.run_last, m_result.code_unit};
    assign m_axis_tuser = m_result.status;
    assign m_axis_tlast = m_result.text_done;

endmodule
`default_nettype wire
